/* rtl/core/text_console_glyph_renderer_top_macros.svh */
// Assertion macros for the text console glyph renderer.
// Used by the port checker; no other dependencies.
`ifndef TEXT_CONSOLE_GLYPH_RENDERER_TOP_MACROS_SVH
`define TEXT_CONSOLE_GLYPH_RENDERER_TOP_MACROS_SVH

// Check on every clock edge while out of reset.
`define TCGR_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error(msg);

// Check on every clock edge, reset included.
`define TCGR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/tcgr_pkg.sv */
// Shared types and constants of the text console glyph renderer.
// No dependencies; the top level, controller, datapath and checker refer to it.
`default_nettype none

package tcgr_pkg;

  localparam int GLYPH_ROWS_DEF  = 16;
  localparam int GLYPH_COUNT_DEF = 256;
  localparam int CELL_WIDTH      = 8;
  localparam int ROW_WRITES      = 16;
  localparam int NEWLINE_STEP    = 18;
  localparam int WRAP_STEP       = 16;
  localparam int ROW_W           = $clog2(ROW_WRITES);
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 32;
  localparam int DIM_W           = 14;

  localparam logic [31:0]      FG_RESET    = 32'hffff_ffff;
  localparam logic [31:0]      ERASE_RESET = 32'h0027_2829;
  localparam logic [DIM_W-1:0] PITCH_RESET = 14'd1024;
  localparam logic [DIM_W-1:0] WIDTH_RESET = 14'd1024;
  localparam logic [31:0]      BASE_RESET  = 32'h0000_0000;
  localparam logic [7:0]       FULL_MASK   = 8'hff;

  typedef enum logic [1:0] {
    KIND_DRAW    = 2'd0,
    KIND_NEWLINE = 2'd1,
    KIND_ERASE   = 2'd2,
    KIND_LOAD    = 2'd3
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FG_COLOR     = 3'd0,
    CFG_ERASE_COLOR  = 3'd1,
    CFG_LINE_PITCH   = 3'd2,
    CFG_SCREEN_WIDTH = 3'd3,
    CFG_FRAME_BASE   = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic             accept;
    logic             setup;
    logic             issue;
    logic             load;
    logic [ROW_W-1:0] rd_row;
    logic             last;
  } cmd_t;

  typedef struct packed {
    logic emits;
  } sts_t;

endpackage

`default_nettype wire

/* rtl/core/tcgr_if.sv */
// Valid/ready channel interfaces for the glyph renderer.
// Depends on nothing; used by the top level.
`default_nettype none

interface tcgr_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] code;
  logic [3:0] glyph_row;
  logic [7:0] row_bits;

  modport source (output valid, kind, code, glyph_row, row_bits, input ready);
  modport sink (input valid, kind, code, glyph_row, row_bits, output ready);
endinterface

interface tcgr_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel_address;
  logic [7:0]  pixel_mask;
  logic [31:0] pixel_color;
  logic        last;

  modport source (output valid, pixel_address, pixel_mask, pixel_color, last,
                  input ready);
  modport sink (input valid, pixel_address, pixel_mask, pixel_color, last,
                output ready);
endinterface

`default_nettype wire

/* rtl/core/text_console_glyph_renderer_top.sv */
// Top level of the text console glyph renderer.
// Depends on tcgr_pkg, tcgr_if, tcgr_ctrl and tcgr_datapath.
//
// Input channel in_i carries items: load font row, draw char, new line,
// erase char. Output channel out_o carries frame buffer row writes
// (address, 8-pixel mask, color, last flag). Registers are written through
// cfg_we_i / cfg_idx_i / cfg_data_i; the user must write them only while
// the block is idle, which the block itself does not enforce. Font loads
// and new lines give no transactions; neither does an erase at column zero.
// A draw or an erase gives 16 row writes: a setup step for the row address,
// a font memory read, then one row write per cycle while the sink accepts.
// SETUP forms the row address; each font row is read, then loaded into the
// output register. The next item is taken once the last row is loaded, and
// the last row waits in the output register while that item is taken. A
// stalled sink holds the output register and stops the row sequencer. Reset
// clears the cursor, restores register defaults and empties the output; the
// font memory is not cleared and must be loaded before use.
`default_nettype none

module text_console_glyph_renderer_top #(
  parameter int GLYPH_ROWS  = tcgr_pkg::GLYPH_ROWS_DEF,
  parameter int GLYPH_COUNT = tcgr_pkg::GLYPH_COUNT_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [tcgr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [tcgr_pkg::CFG_DATA_W-1:0] cfg_data_i,
  tcgr_in_if.sink                              in_i,
  tcgr_out_if.source                           out_o
);

  tcgr_pkg::cmd_t cmd;
  tcgr_pkg::sts_t sts;

  tcgr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  tcgr_datapath #(
    .GLYPH_ROWS  (GLYPH_ROWS),
    .GLYPH_COUNT (GLYPH_COUNT)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .kind_i          (in_i.kind),
    .code_i          (in_i.code),
    .glyph_row_i     (in_i.glyph_row),
    .row_bits_i      (in_i.row_bits),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .pixel_address_o (out_o.pixel_address),
    .pixel_mask_o    (out_o.pixel_mask),
    .pixel_color_o   (out_o.pixel_color),
    .last_o          (out_o.last)
  );

endmodule

`default_nettype wire

/* rtl/core/tcgr_ctrl.sv */
// Controller of the glyph renderer: state machine, row counters, handshakes.
// Depends on tcgr_pkg; drives the datapath by command signals.
`default_nettype none

module tcgr_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  input  wire tcgr_pkg::sts_t sts_i,
  output tcgr_pkg::cmd_t     cmd_o
);

  localparam int IssW = $clog2(tcgr_pkg::ROW_WRITES + 1);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SETUP = 3'b010,
    ST_RUN   = 3'b100
  } state_e;

  state_e                     state_q, state_d;
  logic [IssW-1:0]            iss_cnt_q, iss_cnt_d;
  logic [tcgr_pkg::ROW_W-1:0] ld_cnt_q, ld_cnt_d;
  logic                       rd_valid_q, rd_valid_d;
  logic                       out_valid_q, out_valid_d;
  logic                       accept, issue, load, last;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign load        = (state_q == ST_RUN) && rd_valid_q && (!out_valid_q || out_ready_i);
  assign issue       = (state_q == ST_RUN) && (iss_cnt_q != IssW'(tcgr_pkg::ROW_WRITES))
                       && (!rd_valid_q || load);
  assign last        = (ld_cnt_q == tcgr_pkg::ROW_W'(tcgr_pkg::ROW_WRITES - 1));
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o        = '0;
    cmd_o.accept = accept;
    cmd_o.setup  = (state_q == ST_SETUP);
    cmd_o.issue  = issue;
    cmd_o.load   = load;
    cmd_o.rd_row = iss_cnt_q[tcgr_pkg::ROW_W-1:0];
    cmd_o.last   = last;
  end

  always_comb begin
    state_d     = state_q;
    iss_cnt_d   = iss_cnt_q;
    ld_cnt_d    = ld_cnt_q;
    rd_valid_d  = rd_valid_q;
    out_valid_d = load || (out_valid_q && !out_ready_i);
    unique case (state_q)
      ST_IDLE: begin
        if (accept && sts_i.emits) begin
          state_d = ST_SETUP;
        end
      end
      ST_SETUP: begin
        iss_cnt_d  = '0;
        ld_cnt_d   = '0;
        rd_valid_d = 1'b0;
        state_d    = ST_RUN;
      end
      ST_RUN: begin
        if (issue) begin
          iss_cnt_d  = iss_cnt_q + IssW'(1);
          rd_valid_d = 1'b1;
        end else if (load) begin
          rd_valid_d = 1'b0;
        end
        if (load) begin
          ld_cnt_d = ld_cnt_q + tcgr_pkg::ROW_W'(1);
          if (last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      iss_cnt_q   <= '0;
      ld_cnt_q    <= '0;
      rd_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      iss_cnt_q   <= iss_cnt_d;
      ld_cnt_q    <= ld_cnt_d;
      rd_valid_q  <= rd_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/tcgr_datapath.sv */
// Datapath of the glyph renderer: registers, cursor, font memory, address unit.
// Depends on tcgr_pkg; steered by tcgr_ctrl commands.
`default_nettype none

module tcgr_datapath #(
  parameter int GLYPH_ROWS  = tcgr_pkg::GLYPH_ROWS_DEF,
  parameter int GLYPH_COUNT = tcgr_pkg::GLYPH_COUNT_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [tcgr_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [tcgr_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic [1:0]                     kind_i,
  input  wire logic [7:0]                     code_i,
  input  wire logic [3:0]                     glyph_row_i,
  input  wire logic [7:0]                     row_bits_i,
  input  wire tcgr_pkg::cmd_t                 cmd_i,
  output tcgr_pkg::sts_t                      sts_o,
  output logic [31:0]                         pixel_address_o,
  output logic [7:0]                          pixel_mask_o,
  output logic [31:0]                         pixel_color_o,
  output logic                                last_o
);

  localparam int StoreSize = GLYPH_COUNT * GLYPH_ROWS;
  localparam int Aw        = $clog2(StoreSize);
  localparam int Gw        = $clog2(GLYPH_COUNT);
  localparam int Cw        = 10;
  localparam int Dw        = tcgr_pkg::DIM_W;

  logic [31:0]   fg_q, erase_col_q, base_q;
  logic [Dw-1:0] pitch_q, width_q;
  logic [15:0]   col_q, col_d, line_q, line_d;

  logic [Cw-1:0] code_x;
  logic [Gw-1:0] glyph;
  logic [Aw:0]   gbase, rd_sum;
  logic [Aw-1:0] widx, ridx;
  logic          we;

  logic [7:0]    mem [StoreSize];
  logic [7:0]    rdata_q;

  logic [Aw:0]   gbase_q;
  logic [15:0]   x_q;
  logic [31:0]   color_q;
  logic          erase_q;
  logic [29:0]   prod;
  logic [29:0]   prod_q;
  logic [31:0]   row_addr_q;
  logic [31:0]   out_addr_q, out_color_q;
  logic [7:0]    out_mask_q;
  logic          out_last_q;
  logic [16:0]   col_adv;

  // Glyph index: code modulo glyph count, code below twice the count.
  assign code_x = Cw'(code_i);
  assign glyph  = (code_x >= Cw'(GLYPH_COUNT)) ? Gw'(code_x - Cw'(GLYPH_COUNT))
                                               : Gw'(code_x);
  assign gbase  = (Aw+1)'(glyph) * (Aw+1)'(GLYPH_ROWS);
  assign widx   = Aw'(gbase + (Aw+1)'(glyph_row_i));
  assign we     = cmd_i.accept && (kind_i == tcgr_pkg::KIND_LOAD)
                  && (6'(glyph_row_i) < 6'(GLYPH_ROWS));

  assign rd_sum = gbase_q + (Aw+1)'(cmd_i.rd_row);
  assign ridx   = (rd_sum >= (Aw+1)'(StoreSize)) ? Aw'(rd_sum - (Aw+1)'(StoreSize))
                                                 : Aw'(rd_sum);

  assign sts_o.emits = (kind_i == tcgr_pkg::KIND_DRAW)
                       || ((kind_i == tcgr_pkg::KIND_ERASE)
                           && (col_q >= 16'(tcgr_pkg::CELL_WIDTH)));

  assign prod    = line_q * pitch_q;
  assign col_adv = 17'(col_q + 16'(tcgr_pkg::CELL_WIDTH)) + 17'(tcgr_pkg::CELL_WIDTH);

  always_comb begin
    col_d  = col_q;
    line_d = line_q;
    if (cmd_i.accept) begin
      case (kind_i)
        tcgr_pkg::KIND_DRAW: begin
          if (col_adv > 17'(width_q)) begin
            col_d  = '0;
            line_d = line_q + 16'(tcgr_pkg::WRAP_STEP);
          end else begin
            col_d  = col_q + 16'(tcgr_pkg::CELL_WIDTH);
          end
        end
        tcgr_pkg::KIND_NEWLINE: begin
          col_d  = '0;
          line_d = line_q + 16'(tcgr_pkg::NEWLINE_STEP);
        end
        tcgr_pkg::KIND_ERASE: begin
          if (col_q >= 16'(tcgr_pkg::CELL_WIDTH)) begin
            col_d = col_q - 16'(tcgr_pkg::CELL_WIDTH);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fg_q        <= tcgr_pkg::FG_RESET;
      erase_col_q <= tcgr_pkg::ERASE_RESET;
      pitch_q     <= tcgr_pkg::PITCH_RESET;
      width_q     <= tcgr_pkg::WIDTH_RESET;
      base_q      <= tcgr_pkg::BASE_RESET;
      col_q       <= '0;
      line_q      <= '0;
    end else begin
      col_q  <= col_d;
      line_q <= line_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          tcgr_pkg::CFG_FG_COLOR:     fg_q        <= cfg_data_i;
          tcgr_pkg::CFG_ERASE_COLOR:  erase_col_q <= cfg_data_i;
          tcgr_pkg::CFG_LINE_PITCH:   pitch_q     <= cfg_data_i[Dw-1:0];
          tcgr_pkg::CFG_SCREEN_WIDTH: width_q     <= cfg_data_i[Dw-1:0];
          tcgr_pkg::CFG_FRAME_BASE:   base_q      <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[widx] <= row_bits_i;
    end
    if (cmd_i.issue) begin
      rdata_q <= mem[ridx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      gbase_q <= gbase;
      erase_q <= (kind_i == tcgr_pkg::KIND_ERASE);
      x_q     <= (kind_i == tcgr_pkg::KIND_ERASE) ? col_q - 16'(tcgr_pkg::CELL_WIDTH)
                                                  : col_q;
      color_q <= (kind_i == tcgr_pkg::KIND_ERASE) ? erase_col_q : fg_q;
      prod_q  <= prod;
    end
    if (cmd_i.setup) begin
      row_addr_q <= base_q + 32'(x_q) + 32'(prod_q);
    end else if (cmd_i.load) begin
      row_addr_q <= row_addr_q + 32'(pitch_q);
    end
    if (cmd_i.load) begin
      out_addr_q  <= row_addr_q;
      out_mask_q  <= erase_q ? tcgr_pkg::FULL_MASK : rdata_q;
      out_color_q <= color_q;
      out_last_q  <= cmd_i.last;
    end
  end

  assign pixel_address_o = out_addr_q;
  assign pixel_mask_o    = out_mask_q;
  assign pixel_color_o   = out_color_q;
  assign last_o          = out_last_q;

endmodule

`default_nettype wire

/* rtl/core/tcgr_checker.sv */
// Port checker for the glyph renderer, bound to the top level.
// Depends on tcgr_pkg and the assertion macro header.
`default_nettype none

`include "text_console_glyph_renderer_top_macros.svh"

module tcgr_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_i,
  input wire logic [1:0]  in_kind_i,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [31:0] out_address_i,
  input wire logic [7:0]  out_mask_i,
  input wire logic [31:0] out_color_i,
  input wire logic        out_last_i
);

  `TCGR_ASSERT_ALWAYS(a_no_out_in_reset, clk_i, !rst_ni |-> !out_valid_i, "output valid in reset")
  `TCGR_ASSERT(a_draw_busy, clk_i, rst_ni, in_valid_i && in_ready_i && in_kind_i == tcgr_pkg::KIND_DRAW |=> !in_ready_i, "ready after draw")
  `TCGR_ASSERT(a_mid_char_busy, clk_i, rst_ni, out_valid_i && out_ready_i && !out_last_i |-> !in_ready_i, "ready mid character")
  `TCGR_ASSERT(a_stall_hold, clk_i, rst_ni, out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_address_i) && $stable(out_mask_i) && $stable(out_color_i) && $stable(out_last_i), "stalled output changed")

endmodule

bind text_console_glyph_renderer_top tcgr_checker u_tcgr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .in_kind_i     (in_i.kind),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_address_i (out_o.pixel_address),
  .out_mask_i    (out_o.pixel_mask),
  .out_color_i   (out_o.pixel_color),
  .out_last_i    (out_o.last)
);

`default_nettype wire
